>>> rtl/alsw_pkg.sv
package alsw_pkg;

    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_C1,
        ST_F1,
        ST_C2,
        ST_F2,
        ST_FILL,
        ST_CLEAR
    } state_t;

    typedef enum logic [2:0] {
        SEL_C1,
        SEL_F1,
        SEL_C2,
        SEL_F2,
        SEL_FILL,
        SEL_CLEAR
    } sel_t;

    typedef struct packed {
        logic load_item;
        logic do_map;
        logic load_out;
        sel_t sel;
        logic last;
        logic cnt_init_clear;
        logic cnt_init_fill;
        logic cnt_inc;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic fill_nonempty;
        logic at_fill_hi;
        logic at_seg_hi;
    } status_t;

endpackage

>>> rtl/alsw_ctrl.sv
module alsw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              op,
    input  alsw_pkg::status_t status,
    output logic              in_ready,
    output alsw_pkg::cmd_t    cmd
);

    alsw_pkg::state_t state_reg;
    alsw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alsw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alsw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (op == alsw_pkg::OP_CLEAR) ? alsw_pkg::ST_CLEAR
                                                            : alsw_pkg::ST_MAP;
                end
            end
            alsw_pkg::ST_MAP:
            begin
                state_next = alsw_pkg::ST_C1;
            end
            alsw_pkg::ST_C1:
            begin
                if (status.out_free)
                begin
                    state_next = alsw_pkg::ST_F1;
                end
            end
            alsw_pkg::ST_F1:
            begin
                if (status.out_free)
                begin
                    state_next = alsw_pkg::ST_C2;
                end
            end
            alsw_pkg::ST_C2:
            begin
                if (status.out_free)
                begin
                    state_next = alsw_pkg::ST_F2;
                end
            end
            alsw_pkg::ST_F2:
            begin
                if (status.out_free)
                begin
                    state_next = status.fill_nonempty ? alsw_pkg::ST_FILL
                                                      : alsw_pkg::ST_IDLE;
                end
            end
            alsw_pkg::ST_FILL:
            begin
                if (status.out_free && status.at_fill_hi)
                begin
                    state_next = alsw_pkg::ST_IDLE;
                end
            end
            alsw_pkg::ST_CLEAR:
            begin
                if (status.out_free && status.at_seg_hi)
                begin
                    state_next = alsw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = alsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.sel  = alsw_pkg::SEL_C1;
        in_ready = 1'b0;
        case (state_reg)
            alsw_pkg::ST_IDLE:
            begin
                in_ready           = 1'b1;
                cmd.load_item      = in_valid;
                cmd.cnt_init_clear = in_valid;
            end
            alsw_pkg::ST_MAP:
            begin
                cmd.do_map = 1'b1;
            end
            alsw_pkg::ST_C1:
            begin
                cmd.sel      = alsw_pkg::SEL_C1;
                cmd.load_out = status.out_free;
            end
            alsw_pkg::ST_F1:
            begin
                cmd.sel      = alsw_pkg::SEL_F1;
                cmd.load_out = status.out_free;
            end
            alsw_pkg::ST_C2:
            begin
                cmd.sel      = alsw_pkg::SEL_C2;
                cmd.load_out = status.out_free;
            end
            alsw_pkg::ST_F2:
            begin
                cmd.sel           = alsw_pkg::SEL_F2;
                cmd.load_out      = status.out_free;
                cmd.last          = !status.fill_nonempty;
                cmd.cnt_init_fill = status.out_free;
            end
            alsw_pkg::ST_FILL:
            begin
                cmd.sel      = alsw_pkg::SEL_FILL;
                cmd.load_out = status.out_free;
                cmd.last     = status.at_fill_hi;
                cmd.cnt_inc  = status.out_free;
            end
            alsw_pkg::ST_CLEAR:
            begin
                cmd.sel      = alsw_pkg::SEL_CLEAR;
                cmd.load_out = status.out_free;
                cmd.last     = status.at_seg_hi;
                cmd.cnt_inc  = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/alsw_datapath.sv
module alsw_datapath #(
    parameter int STRIP_PIXELS = 60
) (
    input  logic               clk,
    input  logic               rst_n,
    input  alsw_pkg::cmd_t     cmd,
    output alsw_pkg::status_t  status,
    input  logic [5:0]         seg_start,
    input  logic [5:0]         seg_end,
    input  logic signed [13:0] span_begin,
    input  logic signed [13:0] span_finish,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    input  logic [8:0]         brightness,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         pixel_index,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic               final_write
);

    localparam logic [5:0] MAX_IDX = 6'(STRIP_PIXELS - 1);

    logic [5:0]         s_clip;
    logic [5:0]         e_clip;
    logic               seg_rev;
    logic [5:0]         seg_lo;
    logic [5:0]         seg_hi;
    logic [5:0]         seg_d;

    logic signed [13:0] pos1_reg;
    logic signed [13:0] pos2_reg;
    logic [16:0]        cb_r_reg;
    logic [16:0]        cb_g_reg;
    logic [16:0]        cb_b_reg;
    logic [8:0]         br_clip;

    logic signed [9:0]  fl1_reg;
    logic signed [9:0]  ce1_reg;
    logic [11:0]        f1_reg;
    logic signed [9:0]  fl2_reg;
    logic signed [9:0]  ce2_reg;
    logic [11:0]        f2_reg;
    logic signed [9:0]  fl1_next;
    logic signed [9:0]  ce1_next;
    logic [11:0]        f1_next;
    logic signed [9:0]  fl2_next;
    logic signed [9:0]  ce2_next;
    logic [11:0]        f2_next;

    logic signed [9:0]  fill_a;
    logic signed [9:0]  fill_b;
    logic [5:0]         fill_lo;
    logic [5:0]         fill_hi;

    logic [5:0]         cnt_reg;
    logic [5:0]         idx_sel;
    logic [12:0]        w_sel;

    logic               out_valid_reg;
    logic [5:0]         idx_reg;
    logic [7:0]         r_reg;
    logic [7:0]         g_reg;
    logic [7:0]         b_reg;
    logic               last_reg;

    function automatic logic [5:0] clamp_seg(logic signed [9:0] i, logic [5:0] lo,
                                             logic [5:0] hi);
        logic signed [9:0] lo_s;
        logic signed [9:0] hi_s;
        lo_s = $signed({4'b0, lo});
        hi_s = $signed({4'b0, hi});
        if (i < lo_s)
        begin
            return lo;
        end
        else if (i > hi_s)
        begin
            return hi;
        end
        return i[5:0];
    endfunction

    function automatic logic [7:0] scale(logic [16:0] cb, logic [12:0] w);
        logic [29:0] prod;
        prod = {13'b0, cb} * {17'b0, w};
        return prod[27:20];
    endfunction

    function automatic logic [12:0] floor_weight(logic [11:0] f);
        return (f != 12'd0) ? (13'd4096 - {1'b0, f}) : 13'd0;
    endfunction

    function automatic logic [31:0] map_pos(logic signed [13:0] pos, logic [5:0] d,
                                            logic [5:0] base_px, logic rev);
        logic signed [20:0] m;
        logic signed [21:0] base;
        logic signed [21:0] p;
        logic signed [9:0]  fl;
        logic signed [9:0]  ce;
        m    = 21'(pos) * 21'($signed({1'b0, d}));
        base = $signed({4'b0, base_px, 12'b0});
        p    = rev ? (base - {m[20], m}) : (base + {m[20], m});
        fl   = p[21:12];
        ce   = fl + $signed({9'b0, (p[11:0] != 12'd0)});
        return {fl, ce, p[11:0]};
    endfunction

    assign s_clip  = (seg_start > MAX_IDX) ? MAX_IDX : seg_start;
    assign e_clip  = (seg_end > MAX_IDX) ? MAX_IDX : seg_end;
    assign seg_rev = !(e_clip > s_clip);
    assign seg_lo  = seg_rev ? e_clip : s_clip;
    assign seg_hi  = seg_rev ? s_clip : e_clip;
    assign seg_d   = seg_hi - seg_lo;

    assign br_clip = (brightness > 9'd256) ? 9'd256 : brightness;

    assign {fl1_next, ce1_next, f1_next} = map_pos(pos1_reg, seg_d,
                                                   seg_rev ? seg_hi : seg_lo, seg_rev);
    assign {fl2_next, ce2_next, f2_next} = map_pos(pos2_reg, seg_d,
                                                   seg_rev ? seg_hi : seg_lo, seg_rev);

    assign fill_a  = seg_rev ? ce2_reg : ce1_reg;
    assign fill_b  = seg_rev ? (ce1_reg - 10'sd1) : (ce2_reg - 10'sd1);
    assign fill_lo = clamp_seg(fill_a, seg_lo, seg_hi);
    assign fill_hi = clamp_seg(fill_b, seg_lo, seg_hi);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            pos1_reg <= span_begin;
            pos2_reg <= span_finish;
            cb_r_reg <= {9'b0, red_in} * {8'b0, br_clip};
            cb_g_reg <= {9'b0, green_in} * {8'b0, br_clip};
            cb_b_reg <= {9'b0, blue_in} * {8'b0, br_clip};
        end
        if (cmd.do_map)
        begin
            fl1_reg <= fl1_next;
            ce1_reg <= ce1_next;
            f1_reg  <= f1_next;
            fl2_reg <= fl2_next;
            ce2_reg <= ce2_next;
            f2_reg  <= f2_next;
        end
        if (cmd.cnt_init_clear)
        begin
            cnt_reg <= seg_lo;
        end
        else if (cmd.cnt_init_fill)
        begin
            cnt_reg <= fill_lo;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_comb
    begin
        case (cmd.sel)
            alsw_pkg::SEL_C1:
            begin
                idx_sel = clamp_seg(ce1_reg, seg_lo, seg_hi);
                w_sel   = {1'b0, f1_reg};
            end
            alsw_pkg::SEL_F1:
            begin
                idx_sel = clamp_seg(fl1_reg, seg_lo, seg_hi);
                w_sel   = floor_weight(f1_reg);
            end
            alsw_pkg::SEL_C2:
            begin
                idx_sel = clamp_seg(ce2_reg, seg_lo, seg_hi);
                w_sel   = {1'b0, f2_reg};
            end
            alsw_pkg::SEL_F2:
            begin
                idx_sel = clamp_seg(fl2_reg, seg_lo, seg_hi);
                w_sel   = floor_weight(f2_reg);
            end
            alsw_pkg::SEL_FILL:
            begin
                idx_sel = cnt_reg;
                w_sel   = 13'd4096;
            end
            alsw_pkg::SEL_CLEAR:
            begin
                idx_sel = cnt_reg;
                w_sel   = 13'd0;
            end
            default:
            begin
                idx_sel = cnt_reg;
                w_sel   = 13'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            idx_reg  <= idx_sel;
            r_reg    <= scale(cb_r_reg, w_sel);
            g_reg    <= scale(cb_g_reg, w_sel);
            b_reg    <= scale(cb_b_reg, w_sel);
            last_reg <= cmd.last;
        end
    end

    assign status.out_free      = !out_valid_reg || out_ready;
    assign status.fill_nonempty = (fill_a <= fill_b);
    assign status.at_fill_hi    = (cnt_reg == fill_hi);
    assign status.at_seg_hi     = (cnt_reg == seg_hi);

    assign out_valid   = out_valid_reg;
    assign pixel_index = idx_reg;
    assign red_out     = r_reg;
    assign green_out   = g_reg;
    assign blue_out    = b_reg;
    assign final_write = last_reg;

endmodule

>>> rtl/antialiased_led_span_writer.sv
// Antialiased span writer for one segment of an LED strip. Each input transaction is either
// a draw, which emits two antialiased writes for each end of the span followed by full-color
// writes for the whole pixels between them, or a clear, which writes black to every pixel of
// the segment in ascending order. Items are handled one at a time: a draw is accepted, maps
// both positions onto the strip in the MAP state, then issues one pixel write per cycle while
// the output register can take it; a clear issues its writes at the same rate. The single
// output register takes one pixel write per cycle and holds further writes while the
// downstream side holds m_tready low. The next item is taken in the cycle after the last
// write of the previous one enters the output register, while that write may still wait.
// The segment registers are written through the APB port and should be changed only while
// the block is idle.
module antialiased_led_span_writer #(
    parameter int STRIP_PIXELS = 60
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // span_begin[13:0], span_finish[27:14], red_in[35:28], green_in[43:36],
    // blue_in[51:44], brightness[60:52], zero fill[63:61].
    input  logic [63:0] s_tdata,
    // op[0].
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_index[5:0], red_out[13:6], green_out[21:14], blue_out[29:22], zero fill[31:30].
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    logic [5:0]        seg_start_reg;
    logic [5:0]        seg_end_reg;
    logic              cfg_write;
    alsw_pkg::cmd_t    cmd;
    alsw_pkg::status_t status;
    logic [5:0]        pixel_index;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {26'b0, seg_end_reg} : {26'b0, seg_start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_start_reg <= 6'd0;
            seg_end_reg   <= 6'd59;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                seg_end_reg <= pwdata[5:0];
            end
            else
            begin
                seg_start_reg <= pwdata[5:0];
            end
        end
    end

    alsw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .op       (s_tuser[0]),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    alsw_datapath #(
        .STRIP_PIXELS (STRIP_PIXELS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .seg_start   (seg_start_reg),
        .seg_end     (seg_end_reg),
        .span_begin  ($signed(s_tdata[13:0])),
        .span_finish ($signed(s_tdata[27:14])),
        .red_in      (s_tdata[35:28]),
        .green_in    (s_tdata[43:36]),
        .blue_in     (s_tdata[51:44]),
        .brightness  (s_tdata[60:52]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pixel_index (pixel_index),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .final_write (m_tlast)
    );

    assign m_tdata = {2'b0, blue_out, green_out, red_out, pixel_index};

    a_busy_after_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("Input accepted again while an item is in progress.");

    a_no_overwrite : assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready)
    ) else $error("Pending pixel write overwritten.");

    a_idle_after_last : assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.load_out && cmd.last) |=> s_tready
    ) else $error("Controller not idle after the final pixel write.");

    a_last_loaded : assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid) && m_tlast) |-> $past(cmd.last)
    ) else $error("Final marker on a write not issued as final.");

endmodule
